@@ hw/rtl/breath_cycle_sequencer_assert.svh @@
// Assertion macros shared by the breath cycle sequencer RTL.
`ifndef BREATH_CYCLE_SEQUENCER_ASSERT_SVH
`define BREATH_CYCLE_SEQUENCER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define BCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bcs_pkg.sv @@
// Package: types and constants of the breath cycle sequencer.
`timescale 1ns / 1ps
package bcs_pkg;

  localparam int unsigned MinutesMs = 60000;
  localparam int unsigned RateRst   = 15;
  localparam int unsigned IeRst     = 1;

  localparam logic [15:0] MINUTE_MS = 16'(MinutesMs);
  localparam logic [5:0]  RATE_RST  = 6'(RateRst);
  localparam logic [2:0]  IE_RST    = 3'(IeRst);
  localparam logic [15:0] CYC_RST   = 16'(MinutesMs / RateRst);
  localparam logic [15:0] INS_RST   = 16'(MinutesMs / RateRst / (IeRst + 1));
  localparam logic [15:0] EXP_RST   = 16'(MinutesMs / RateRst -
                                          MinutesMs / RateRst / (IeRst + 1));
  localparam logic [7:0]  POS_SAT   = 8'hFF;

  typedef enum logic [2:0] {
    PH_HOMING    = 3'd0,
    PH_START_INS = 3'd1,
    PH_INS       = 3'd2,
    PH_START_EXP = 3'd3,
    PH_EXP       = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_HIGHEST = 2'd1,
    CMD_LOWEST  = 2'd2
  } motor_cmd_e;

  typedef enum logic [1:0] {
    REG_BREATH_RATE = 2'd0,
    REG_IE_DIVISOR  = 2'd1
  } cfg_reg_e;

  // request to the serial divider
  typedef struct packed {
    logic        start;
    logic [15:0] rem;    // initial partial remainder, below den
    logic [15:0] num;    // dividend bits, fed MSB first
    logic [15:0] den;
    logic [4:0]  steps;  // quotient bits to produce
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quo;
  } div_rsp_t;

endpackage

@@ hw/rtl/bcs_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bcs_div
  import bcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] num_q, num_d;
  logic [15:0] den_q, den_d;
  logic [15:0] quo_q, quo_d;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem_q, num_q[15]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem;
      num_d  = req_i.num;
      den_d  = req_i.den;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
      num_d = {num_q[14:0], 1'b0};
      quo_d = {quo_q[14:0], fits};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ hw/rtl/breath_cycle_sequencer.sv @@
// Top level: ventilator breath cycle sequencer.
//
// One request per timer tick on the in channel (valid/ready), one result per
// request on the out channel. Configuration writes (breath_rate at index 0,
// ie_divisor at index 1) come on the cfg channel while the block is idle.
// After a write the cycle and inspiration times are recomputed by the serial
// divider: 60000/rate then cycle/(ie+1), 16 quotient steps each. The block is
// busy until both divisions are done and takes no request in that time.
// A tick goes from request to result through offset add, *127 product and
// saturation compare, the shared bit-serial divider for the cycle position
// (load, 8 quotient steps, done), then a commit step. A saturated position
// skips the divider. One tick is worked on at a time, so no new request is
// taken until the previous tick has committed.
// Results sit in an output register; a new request is taken while a result
// waits, and a finished tick holds its commit until that register frees up.
// Reset puts the phase at homing, clears counters, flags and latched volumes,
// and loads rate 15 and ratio 1 with their derived times.
`timescale 1ns / 1ps
module breath_cycle_sequencer
  import bcs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [5:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       now_ms_i,
  input  logic              force_start_i,
  input  logic              force_stop_i,
  input  logic              motor_moving_i,
  input  logic              motor_at_lowest_i,
  input  logic [11:0]       ins_vol_ml_i,
  input  logic signed [12:0] exs_vol_ml_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        phase_o,
  output logic [1:0]        motor_cmd_o,
  output logic              motor_disable_o,
  output logic [7:0]        breath_pos_o,
  output logic [15:0]       cycle_total_o,
  output logic              ended_while_moving_o,
  output logic [11:0]       mean_volume_o,
  output logic              halted_o,
  output logic              display_update_o
);

  `include "breath_cycle_sequencer_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CFG_CYC,
    ST_CFG_INS,
    ST_OFFSET,
    ST_MUL,
    ST_CMP,
    ST_POS,
    ST_COMMIT
  } state_e;

  state_e      st_q;
  logic        start_q, start_d;

  logic [5:0]  rate_q;
  logic [2:0]  ie_q;
  logic [15:0] cyc_q, ins_q, exp_q;

  phase_e      phase_q, phase_d;
  logic [31:0] start_ms_q, start_ms_d;
  logic        halted_q, halted_d;
  logic        pend_q, pend_d;
  logic        ended_q, ended_d;
  logic [15:0] count_q, count_d;
  logic [11:0] lat_ins_q, lat_ins_d;
  logic [11:0] lat_exs_q, lat_exs_d;

  // tick request
  logic [31:0] now_q;
  logic        fstart_q, fstop_q, moving_q, lowest_q;
  logic [11:0] ins_vol_q;
  logic [12:0] exs_vol_q;
  logic [31:0] elapsed_q;
  logic [32:0] numer_q;
  logic [23:0] prod_q;
  logic        sat_q;
  logic [7:0]  pos_q;

  logic        out_vld_q;
  logic        in_acc, cfg_acc, commit;
  logic [5:0]  rate_eff;
  logic [12:0] exs_neg;
  logic [12:0] exs_mag;
  logic [12:0] vol_sum;
  motor_cmd_e  cmd_d;
  logic        disable_d, disp_d;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  bcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o = st_q == ST_IDLE;
  assign in_ready_o  = (st_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && in_ready_o;
  assign commit      = (st_q == ST_COMMIT) && (!out_vld_q || out_ready_i);
  assign rate_eff    = (rate_q == 6'd0) ? 6'd1 : rate_q;

  // divider start pulse
  always_comb begin
    start_d = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        start_d = cfg_acc && (cfg_index_i == REG_BREATH_RATE ||
                              cfg_index_i == REG_IE_DIVISOR);
      end
      ST_CFG_CYC: begin
        start_d = div_rsp.done;
      end
      ST_CMP: begin
        start_d = !(sat_q || prod_q >= {cyc_q, 8'h00});
      end
      default: begin
        start_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    div_req       = '0;
    div_req.start = start_q;
    unique case (st_q)
      ST_CFG_CYC: begin
        div_req.num   = MINUTE_MS;
        div_req.den   = {10'd0, rate_eff};
        div_req.steps = 5'd16;
      end
      ST_CFG_INS: begin
        div_req.num   = cyc_q;
        div_req.den   = {12'd0, 1'b0, ie_q} + 16'd1;
        div_req.steps = 5'd16;
      end
      ST_POS: begin
        div_req.rem   = prod_q[23:8];
        div_req.num   = {prod_q[7:0], 8'h00};
        div_req.den   = cyc_q;
        div_req.steps = 5'd8;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // expired volume magnitude, -4096 saturates
  assign exs_neg = 13'(~exs_vol_q + 13'd1);
  assign exs_mag = exs_vol_q[12] ? exs_neg : exs_vol_q;
  assign vol_sum = {1'b0, lat_ins_d} + {1'b0, lat_exs_d};

  always_comb begin
    phase_d    = phase_q;
    start_ms_d = start_ms_q;
    halted_d   = halted_q && !fstart_q;
    pend_d     = pend_q;
    ended_d    = ended_q;
    count_d    = count_q;
    lat_ins_d  = lat_ins_q;
    lat_exs_d  = lat_exs_q;
    cmd_d      = CMD_NONE;
    disable_d  = 1'b0;
    disp_d     = 1'b0;
    if (!halted_d) begin
      if (fstop_q) begin
        halted_d  = 1'b1;
        disable_d = 1'b1;
      end else begin
        unique case (phase_q)
          PH_START_INS: begin
            lat_ins_d  = ins_vol_q;
            lat_exs_d  = exs_mag[12] ? 12'hFFF : exs_mag[11:0];
            start_ms_d = now_q;
            cmd_d      = CMD_HIGHEST;
            phase_d    = PH_INS;
            disp_d     = 1'b1;
            pend_d     = 1'b0;
          end
          PH_INS: begin
            if (elapsed_q > {16'd0, ins_q}) begin
              if (moving_q) begin
                pend_d = 1'b1;
              end
              phase_d = PH_START_EXP;
            end
          end
          PH_START_EXP: begin
            ended_d    = pend_q;
            start_ms_d = now_q;
            cmd_d      = CMD_LOWEST;
            phase_d    = PH_EXP;
          end
          PH_EXP: begin
            if (elapsed_q > {16'd0, exp_q} && lowest_q) begin
              phase_d    = PH_START_INS;
              start_ms_d = now_q;
              count_d    = count_q + 16'd1;
            end
          end
          default: begin
            phase_d = PH_START_INS;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q                 <= ST_IDLE;
      start_q              <= 1'b0;
      rate_q               <= RATE_RST;
      ie_q                 <= IE_RST;
      cyc_q                <= CYC_RST;
      ins_q                <= INS_RST;
      exp_q                <= EXP_RST;
      phase_q              <= PH_HOMING;
      start_ms_q           <= '0;
      halted_q             <= 1'b0;
      pend_q               <= 1'b0;
      ended_q              <= 1'b0;
      count_q              <= '0;
      lat_ins_q            <= '0;
      lat_exs_q            <= '0;
      out_vld_q            <= 1'b0;
      phase_o              <= PH_HOMING;
      motor_cmd_o          <= CMD_NONE;
      motor_disable_o      <= 1'b0;
      breath_pos_o         <= '0;
      cycle_total_o        <= '0;
      ended_while_moving_o <= 1'b0;
      mean_volume_o        <= '0;
      halted_o             <= 1'b0;
      display_update_o     <= 1'b0;
    end else begin
      start_q <= start_d;
      if (out_vld_q && out_ready_i && !commit) begin
        out_vld_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (cfg_acc) begin
            if (cfg_index_i == REG_BREATH_RATE) begin
              rate_q <= cfg_data_i;
              st_q   <= ST_CFG_CYC;
            end else if (cfg_index_i == REG_IE_DIVISOR) begin
              ie_q <= cfg_data_i[2:0];
              st_q <= ST_CFG_CYC;
            end
          end else if (in_acc) begin
            st_q <= ST_OFFSET;
          end
        end
        ST_CFG_CYC: begin
          if (div_rsp.done) begin
            cyc_q <= div_rsp.quo;
            st_q  <= ST_CFG_INS;
          end
        end
        ST_CFG_INS: begin
          if (div_rsp.done) begin
            ins_q <= div_rsp.quo;
            exp_q <= cyc_q - div_rsp.quo;
            st_q  <= ST_IDLE;
          end
        end
        ST_OFFSET: begin
          st_q <= ST_MUL;
        end
        ST_MUL: begin
          st_q <= ST_CMP;
        end
        ST_CMP: begin
          if (sat_q || prod_q >= {cyc_q, 8'h00}) begin
            st_q <= ST_COMMIT;
          end else begin
            st_q <= ST_POS;
          end
        end
        ST_POS: begin
          if (div_rsp.done) begin
            st_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (commit) begin
            st_q                 <= ST_IDLE;
            out_vld_q            <= 1'b1;
            phase_q              <= phase_d;
            start_ms_q           <= start_ms_d;
            halted_q             <= halted_d;
            pend_q               <= pend_d;
            ended_q              <= ended_d;
            count_q              <= count_d;
            lat_ins_q            <= lat_ins_d;
            lat_exs_q            <= lat_exs_d;
            phase_o              <= phase_d;
            motor_cmd_o          <= cmd_d;
            motor_disable_o      <= disable_d;
            breath_pos_o         <= pos_q;
            cycle_total_o        <= count_d;
            ended_while_moving_o <= ended_d;
            mean_volume_o        <= vol_sum[12:1];
            halted_o             <= halted_d;
            display_update_o     <= disp_d;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  // tick datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q     <= now_ms_i;
      fstart_q  <= force_start_i;
      fstop_q   <= force_stop_i;
      moving_q  <= motor_moving_i;
      lowest_q  <= motor_at_lowest_i;
      ins_vol_q <= ins_vol_ml_i;
      exs_vol_q <= exs_vol_ml_i;
      elapsed_q <= now_ms_i - start_ms_q;
    end
    if (st_q == ST_OFFSET) begin
      numer_q <= {1'b0, elapsed_q} +
                 ((phase_q == PH_EXP) ? {17'd0, ins_q} : 33'd0);
    end
    if (st_q == ST_MUL) begin
      sat_q  <= |numer_q[32:17];
      prod_q <= 24'({numer_q[16:0], 7'd0}) - 24'(numer_q[16:0]);
    end
    if (st_q == ST_CMP) begin
      pos_q <= POS_SAT;
    end
    if (st_q == ST_POS && div_rsp.done) begin
      pos_q <= div_rsp.quo[7:0];
    end
  end

  assign out_valid_o = out_vld_q;

  `BCS_ASSERT_NOW(a_cmd_not_halted, out_vld_q && motor_cmd_o != CMD_NONE, !halted_o,
                  "motor command issued while halted")
  `BCS_ASSERT_NOW(a_disp_with_cmd, out_vld_q && display_update_o,
                  motor_cmd_o == CMD_HIGHEST, "display update without inspiration move")
  `BCS_ASSERT_NOW(a_disable_halts, out_vld_q && motor_disable_o, halted_o,
                  "motor disabled without halt")
  `BCS_ASSERT_NOW(a_div_owned, div_rsp.busy,
                  st_q == ST_CFG_CYC || st_q == ST_CFG_INS || st_q == ST_POS,
                  "divider busy outside a dividing state")
  `BCS_ASSERT_NEXT(a_count_on_commit, st_q != ST_COMMIT, $stable(count_q),
                   "cycle counter changed outside commit")

endmodule
